@@ rtl/hsx_pkg.sv @@
// Shared types and constants for the HMAC-SHA256 counter-mode keystream cipher.
// Holds the request queue entry type, SHA-256 constants and a rotate helper function.
// Depends on nothing.
`default_nettype none

package hsx_pkg;

   // Width of a byte position inside a 32-byte keystream block.
   localparam int POS_W = 5;

   // Configuration register indexes.
   localparam logic [7:0] CSR_KEY0 = 8'd0;
   localparam logic [7:0] CSR_KEY1 = 8'd1;
   localparam logic [7:0] CSR_KEY2 = 8'd2;
   localparam logic [7:0] CSR_KEY3 = 8'd3;

   // HMAC pads and padded message lengths in bits.
   localparam logic [7:0]  IPAD      = 8'h36;
   localparam logic [7:0]  OPAD      = 8'h5c;
   localparam logic [7:0]  PAD_START = 8'h80;
   localparam logic [63:0] INNER_LEN = 64'd576;
   localparam logic [63:0] OUTER_LEN = 64'd768;

   // SHA-256 initial hash value, word 0 in the top bits.
   localparam logic [255:0] SHA_INIT = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   // SHA-256 round constants.
   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   // One queued request: the byte, its flags and the block it belongs to.
   typedef struct packed {
      logic             start;
      logic [63:0]      ctr;
      logic [POS_W-1:0] pos;
      logic [7:0]       data;
      logic             last;
   } item_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

`default_nettype wire

@@ rtl/hsx_front.sv @@
// Front end: accepts request bytes, tracks block position and counter,
// and queues classified requests for the back end. Uses hsx_pkg.
`default_nettype none

module hsx_front #(
   parameter int DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [7:0]        req_data_in,
   input  wire logic              req_last_in,
   output logic                   head_valid,
   output hsx_pkg::item_type      head,
   input  wire logic              head_pop
);
   import hsx_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           queue_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [63:0]        ctr_ff;
   logic [POS_W-1:0]   pos_ff;
   logic               accept;
   item_type           entry_in;

   assign req_full   = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];
   assign accept     = req_push && !req_full;

   // Classify the request: the first byte of a block asks for a new keystream.
   always_comb begin
      entry_in.start = (pos_ff == '0);
      entry_in.ctr   = ctr_ff;
      entry_in.pos   = pos_ff;
      entry_in.data  = req_data_in;
      entry_in.last  = req_last_in;
   end

   // Block position and counter; the last byte restarts both.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff <= '0;
         pos_ff <= '0;
      end else if (accept) begin
         if (req_last_in) begin
            ctr_ff <= '0;
            pos_ff <= '0;
         end else begin
            if (pos_ff == '0) begin
               ctr_ff <= ctr_ff + 64'd1;
            end
            pos_ff <= pos_ff + POS_W'(1);
         end
      end
   end

   // Queue pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (head_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (accept && !head_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (!accept && head_pop) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/hsx_sha_core.sv @@
// One SHA-256 compression, one round per clock; done rises when digest holds the result.
// Uses hsx_pkg for the round constants and rotate function.
`default_nettype none

module hsx_sha_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [255:0] h_in,
   input  wire logic [511:0] block,
   output logic              done,
   output logic [255:0]      digest
);
   import hsx_pkg::*;

   logic [31:0] v_ff [8];
   logic [31:0] hin_ff [8];
   logic [31:0] w_ff [16];
   logic [5:0]  round_ff;
   logic        busy_ff, fin_ff, done_ff;
   logic [255:0] digest_ff;
   logic [31:0] big_s1, ch, t1, big_s0, maj, t2, sig0, sig1, w_new;

   // Round function and message schedule.
   always_comb begin
      big_s1 = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch     = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1     = v_ff[7] + big_s1 + ch + ROUND_K[round_ff] + w_ff[0];
      big_s0 = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      maj    = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2     = big_s0 + maj;
      sig0   = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      sig1   = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new  = w_ff[0] + sig0 + w_ff[9] + sig1;
   end

   // Round sequencing.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         fin_ff   <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= '0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= busy_ff && (round_ff == 6'd63);
         if (start) begin
            busy_ff  <= 1'b1;
            round_ff <= '0;
         end else if (busy_ff) begin
            round_ff <= round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Working variables, schedule window and final addition.
   always_ff @(posedge clock) begin
      if (start) begin
         for (int i = 0; i < 8; i++) begin
            v_ff[i]   <= h_in[255 - 32*i -: 32];
            hin_ff[i] <= h_in[255 - 32*i -: 32];
         end
         for (int i = 0; i < 16; i++) begin
            w_ff[i] <= block[511 - 32*i -: 32];
         end
      end else if (busy_ff) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= w_new;
      end
      if (fin_ff) begin
         for (int i = 0; i < 8; i++) begin
            digest_ff[255 - 32*i -: 32] <= hin_ff[i] + v_ff[i];
         end
      end
   end

   assign done   = done_ff;
   assign digest = digest_ff;

endmodule

`default_nettype wire

@@ rtl/hsx_back.sv @@
// Back end: runs the four compressions of HMAC-SHA256 per block, then XORs
// queued request bytes with the keystream into the output register.
// Uses hsx_pkg and hsx_sha_core.
`default_nettype none

module hsx_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [255:0]     key,
   input  wire logic             head_valid,
   input  wire hsx_pkg::item_type head,
   output logic                  head_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic [7:0]            rsp_data_out,
   output logic                  rsp_last_out
);
   import hsx_pkg::*;

   // Compression phases of one HMAC.
   localparam logic [1:0] PH_INNER_KEY = 2'd0;
   localparam logic [1:0] PH_INNER_CTR = 2'd1;
   localparam logic [1:0] PH_OUTER_KEY = 2'd2;
   localparam logic [1:0] PH_OUTER_TAG = 2'd3;

   logic         hashing_ff, core_start_ff, ks_ok_ff, out_valid_ff;
   logic [1:0]   phase_ff;
   logic [63:0]  ctr_ff;
   logic [255:0] chain_ff, inner_ff, ks_ff;
   logic [7:0]   out_data_ff;
   logic         out_last_ff;
   logic [511:0] core_block;
   logic [255:0] core_h;
   logic         core_done;
   logic [255:0] core_digest;
   logic         need_hash;

   assign need_hash = head_valid && head.start && !ks_ok_ff && !hashing_ff;
   assign head_pop  = head_valid && !hashing_ff && (!head.start || ks_ok_ff)
                      && (!out_valid_ff || rsp_pop);

   // Message block and chaining value for the current phase.
   always_comb begin
      unique case (phase_ff)
         PH_INNER_KEY: begin
            core_block = {key ^ {32{IPAD}}, {32{IPAD}}};
            core_h     = SHA_INIT;
         end
         PH_INNER_CTR: begin
            core_block = {ctr_ff, PAD_START, 376'd0, INNER_LEN};
            core_h     = chain_ff;
         end
         PH_OUTER_KEY: begin
            core_block = {key ^ {32{OPAD}}, {32{OPAD}}};
            core_h     = SHA_INIT;
         end
         PH_OUTER_TAG: begin
            core_block = {inner_ff, PAD_START, 184'd0, OUTER_LEN};
            core_h     = chain_ff;
         end
         default: begin
            core_block = '0;
            core_h     = SHA_INIT;
         end
      endcase
   end

   hsx_sha_core u_core (
      .clock  (clock),
      .reset  (reset),
      .start  (core_start_ff),
      .h_in   (core_h),
      .block  (core_block),
      .done   (core_done),
      .digest (core_digest)
   );

   // Keystream sequencer control.
   always_ff @(posedge clock) begin
      if (reset) begin
         hashing_ff    <= 1'b0;
         core_start_ff <= 1'b0;
         ks_ok_ff      <= 1'b0;
         phase_ff      <= PH_INNER_KEY;
      end else begin
         core_start_ff <= 1'b0;
         if (need_hash) begin
            hashing_ff    <= 1'b1;
            core_start_ff <= 1'b1;
            phase_ff      <= PH_INNER_KEY;
         end else if (core_done) begin
            if (phase_ff == PH_OUTER_TAG) begin
               hashing_ff <= 1'b0;
               ks_ok_ff   <= 1'b1;
            end else begin
               phase_ff      <= phase_ff + 2'd1;
               core_start_ff <= 1'b1;
            end
         end
         if (head_pop && head.start) begin
            ks_ok_ff <= 1'b0;
         end
      end
   end

   // Keystream datapath registers.
   always_ff @(posedge clock) begin
      if (need_hash) begin
         ctr_ff <= head.ctr;
      end
      if (core_done) begin
         chain_ff <= core_digest;
         if (phase_ff == PH_INNER_CTR) begin
            inner_ff <= core_digest;
         end
         if (phase_ff == PH_OUTER_TAG) begin
            ks_ff <= core_digest;
         end
      end
   end

   // Output register: holds one finished request until it is popped.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (head_pop) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         out_data_ff <= head.data ^ ks_ff[{~head.pos, 3'b111} -: 8];
         out_last_ff <= head.last;
      end
   end

   assign rsp_empty    = !out_valid_ff;
   assign rsp_data_out = out_data_ff;
   assign rsp_last_out = out_last_ff;

   // No request leaves the queue while a keystream is being computed.
   assert property (@(posedge clock) disable iff (reset) hashing_ff |-> !head_pop)
      else $error("request consumed during keystream computation");

   // A block's first byte is only used once its keystream is ready.
   assert property (@(posedge clock) disable iff (reset)
                    (head_pop && head.start) |-> ks_ok_ff)
      else $error("block start consumed without fresh keystream");

   // The compression core reports completion only for an active HMAC.
   assert property (@(posedge clock) disable iff (reset) core_done |-> hashing_ff)
      else $error("compression finished with no HMAC in progress");

   // A waiting result is never overwritten before it is popped.
   assert property (@(posedge clock) disable iff (reset)
                    (out_valid_ff && !rsp_pop) |-> !head_pop)
      else $error("output register overwritten");

endmodule

`default_nettype wire

@@ rtl/hmac_sha256_ctr_keystream_xor.sv @@
// HMAC-SHA256 counter-mode stream cipher, one byte per request.
// Request channel: push/full with req_data_in and req_last_in; a request is
// taken at a clock edge with push high and full low. Response channel:
// empty/pop; the oldest response sits on rsp_data_out and rsp_last_out while
// empty is low and leaves at an edge with pop high and empty low.
// Configuration: csr_valid/csr_ready write of key words 0..3 by csr_index;
// csr_ready is always high. Write the key only while the block is idle.
// Each 32-byte block needs a keystream of four SHA-256 compressions that
// run one after another, one round per cycle, before the first byte of the
// block gets its response; later bytes of the block go through the output
// register without a new keystream. Sustained rate is set by the round loop.
// A small request queue keeps accepting bytes while the keystream is built
// and while a response waits. When the receiver stalls, the response holds
// and the queue fills until full rises. Reset clears the key, the block
// counter, the position, the queue and the response register.
`default_nettype none

module hmac_sha256_ctr_keystream_xor #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_data_in,
   input  wire logic        req_last_in,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_data_out,
   output logic             rsp_last_out,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import hsx_pkg::*;

   logic [63:0] key0_ff, key1_ff, key2_ff, key3_ff;
   logic        head_valid, head_pop;
   item_type    head;

   assign csr_ready = 1'b1;

   // Key registers; writes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= '0;
         key1_ff <= '0;
         key2_ff <= '0;
         key3_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_KEY0: key0_ff <= csr_data;
            CSR_KEY1: key1_ff <= csr_data;
            CSR_KEY2: key2_ff <= csr_data;
            CSR_KEY3: key3_ff <= csr_data;
            default: ;
         endcase
      end
   end

   hsx_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data_in (req_data_in),
      .req_last_in (req_last_in),
      .head_valid  (head_valid),
      .head        (head),
      .head_pop    (head_pop)
   );

   hsx_back u_back (
      .clock        (clock),
      .reset        (reset),
      .key          ({key0_ff, key1_ff, key2_ff, key3_ff}),
      .head_valid   (head_valid),
      .head         (head),
      .head_pop     (head_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data_out (rsp_data_out),
      .rsp_last_out (rsp_last_out)
   );

endmodule

`default_nettype wire
